// ----- sv/rme_pkg.sv -----
// Shared constants and the arctangent table for the rotation-to-Euler pipeline.
`default_nettype none

package rme_pkg;

  // Angle accumulator width (Q.29 radians plus sign and headroom)
  localparam int ANG_W      = 34;
  // Rounded angle out of a CORDIC lane: angle bits [ANG_W:16]
  localparam int ANG_OUT_W  = ANG_W + 1 - 16;
  // CORDIC datapath width
  localparam int CW_X       = 64;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_ROUND   = 34'sd32768;
  localparam logic signed [ANG_OUT_W-1:0] OUT_PI      = 19'sd25736;
  localparam logic signed [ANG_OUT_W-1:0] OUT_HALF_PI = 19'sd12868;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [14:0] THRESHOLD_RESET = 15'd1;

  // atan(2^-i) in Q.29, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      5'd24: v = 34'sd32;
      5'd25: v = 34'sd16;
      5'd26: v = 34'sd8;
      5'd27: v = 34'sd4;
      5'd28: v = 34'sd2;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rotation_matrix_to_euler.sv -----
// Throughput: one matrix per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall freezes every stage in place.
// Stages: input, squares, sum, one square-root bit per stage, branch select,
// CORDIC fold, one micro-rotation per stage, rounding, clamp.
// Reset: rst_n synchronous active low; clears valid bits, threshold resets to 1.
`default_nettype none

module rotation_matrix_to_euler #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r00,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r10,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r11,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r12,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r20,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r21,
  input  wire logic signed [DATA_WIDTH-1:0]         in_r22,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [15:0]                        out_roll,
  output logic signed [14:0]                        out_pitch,
  output logic signed [15:0]                        out_yaw,
  output logic                                      out_singular,
  // configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rme_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);
  import rme_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int SQW = 2 * W;
  localparam int TW  = 2 * W + 1;
  localparam int MW  = 7 * W;
  localparam int D   = W + 2;
  localparam int CMW = (W > 15) ? W : 15;
  localparam int LAT = W + N + 7;

  logic en;
  logic [LAT-1:0] vld_r;

  // Configuration register
  logic [14:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) begin
      thr_r <= pwdata[14:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {17'd0, thr_r} : 32'd0;

  // Global advance: output empty or being taken
  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Input capture
  logic [MW-1:0] mat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r <= {in_r00, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22};
    end
  end

  // Matrix delay line alongside squares, sum and square root
  logic [MW-1:0] mat_d_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      mat_d_r[0] <= mat_r;
      for (int k = 1; k < D; k++) begin
        mat_d_r[k] <= mat_d_r[k-1];
      end
    end
  end

  // Squares of r00 and r10
  logic signed [W-1:0]   m00, m10;
  logic signed [SQW-1:0] p0_r, p1_r;

  assign m00 = mat_r[7*W-1:6*W];
  assign m10 = mat_r[6*W-1:5*W];

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= m00 * m00;
      p1_r <= m10 * m10;
    end
  end

  // Square root, one result bit per stage
  logic [SQW-1:0] rem_r [W+1];
  logic [W-1:0]   res_r [W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= p0_r[SQW-1:0] + p1_r[SQW-1:0];
      res_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    localparam int B = W - 1 - j;
    logic [TW-1:0] trial;
    logic [TW-1:0] rem_x;

    assign trial = ({{(W+1){1'b0}}, res_r[j]} << (B + 1))
                 + ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
    assign rem_x = {1'b0, rem_r[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_x >= trial) begin
          rem_r[j+1] <= SQW'(rem_x - trial);
          res_r[j+1] <= res_r[j] | (W'(1) << B);
        end else begin
          rem_r[j+1] <= rem_r[j];
          res_r[j+1] <= res_r[j];
        end
      end
    end
  end

  // Branch select and atan2 operands
  logic [MW-1:0]       md;
  logic signed [W:0]   e00, e10, e11, e12, e20, e21, e22;
  logic [W-1:0]        sy;
  logic                sing;
  logic signed [W:0]   roll_y_r, roll_x_r, yaw_y_r, yaw_x_r, pit_y_r, pit_x_r;
  logic                sing_r;

  assign md  = mat_d_r[D-1];
  assign sy  = res_r[W];
  assign e00 = {md[7*W-1], md[7*W-1:6*W]};
  assign e10 = {md[6*W-1], md[6*W-1:5*W]};
  assign e11 = {md[5*W-1], md[5*W-1:4*W]};
  assign e12 = {md[4*W-1], md[4*W-1:3*W]};
  assign e20 = {md[3*W-1], md[3*W-1:2*W]};
  assign e21 = {md[2*W-1], md[2*W-1:W]};
  assign e22 = {md[W-1],   md[W-1:0]};
  assign sing = CMW'(sy) < CMW'(thr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r   <= sing;
      roll_y_r <= sing ? -e12 : e21;
      roll_x_r <= sing ? e11 : e22;
      yaw_y_r  <= e10;
      yaw_x_r  <= e00;
      pit_y_r  <= -e20;
      pit_x_r  <= {1'b0, sy};
    end
  end

  // Three CORDIC lanes
  logic signed [ANG_OUT_W-1:0] roll_a, yaw_a, pit_a;

  rme_cordic #(.DATA_WIDTH(W), .CORDIC_STAGES(N)) u_roll (
    .clk(clk), .en(en), .y_in(roll_y_r), .x_in(roll_x_r), .ang(roll_a)
  );

  rme_cordic #(.DATA_WIDTH(W), .CORDIC_STAGES(N)) u_yaw (
    .clk(clk), .en(en), .y_in(yaw_y_r), .x_in(yaw_x_r), .ang(yaw_a)
  );

  rme_cordic #(.DATA_WIDTH(W), .CORDIC_STAGES(N)) u_pitch (
    .clk(clk), .en(en), .y_in(pit_y_r), .x_in(pit_x_r), .ang(pit_a)
  );

  // Singular flag follows the CORDIC latency
  logic sing_d_r [N+2];

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d_r[0] <= sing_r;
      for (int k = 1; k < N + 2; k++) begin
        sing_d_r[k] <= sing_d_r[k-1];
      end
    end
  end

  // Clamp and output register
  logic signed [ANG_OUT_W-1:0] roll_c, yaw_c, pit_c;
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pit_r;
  logic               sing_o_r;

  always_comb begin
    roll_c = roll_a;
    if (roll_a > OUT_PI) roll_c = OUT_PI;
    else if (roll_a < -OUT_PI) roll_c = -OUT_PI;
    yaw_c = yaw_a;
    if (yaw_a > OUT_PI) yaw_c = OUT_PI;
    else if (yaw_a < -OUT_PI) yaw_c = -OUT_PI;
    pit_c = pit_a;
    if (pit_a > OUT_HALF_PI) pit_c = OUT_HALF_PI;
    else if (pit_a < -OUT_HALF_PI) pit_c = -OUT_HALF_PI;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r   <= roll_c[15:0];
      pit_r    <= pit_c[14:0];
      yaw_r    <= sing_d_r[N+1] ? '0 : yaw_c[15:0];
      sing_o_r <= sing_d_r[N+1];
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_roll     = roll_r;
  assign out_pitch    = pit_r;
  assign out_yaw      = yaw_r;
  assign out_singular = sing_o_r;

  // Checks
  a_yaw_zero_when_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_yaw == 16'sd0)
    else $error("yaw nonzero on singular result");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch <= 15'sd12868) && (out_pitch >= -15'sd12868))
    else $error("pitch out of range");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- sv/rme_cordic.sv -----
// Pipelined vectoring CORDIC lane computing a rounded atan2(y, x).
`default_nettype none

module rme_cordic #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    en,
  input  wire logic signed [DATA_WIDTH:0]              y_in,
  input  wire logic signed [DATA_WIDTH:0]              x_in,
  output logic signed [rme_pkg::ANG_OUT_W-1:0]         ang
);
  import rme_pkg::*;

  localparam int IW = DATA_WIDTH + 1;
  localparam int SH = 60 - DATA_WIDTH;

  logic signed [CW_X-1:0]  x_r [CORDIC_STAGES+1];
  logic signed [CW_X-1:0]  y_r [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] z_r [CORDIC_STAGES+1];
  logic                    zero_r [CORDIC_STAGES+1];
  logic signed [ANG_OUT_W-1:0] ang_r;

  logic signed [CW_X-1:0]  xe, ye, xp, yp;
  logic signed [ANG_W-1:0] zp;
  logic signed [ANG_W:0]   zrnd;

  // Quadrant fold into the right half plane
  always_comb begin
    xe = {{(CW_X-IW){x_in[IW-1]}}, x_in};
    ye = {{(CW_X-IW){y_in[IW-1]}}, y_in};
    xp = xe;
    yp = ye;
    zp = '0;
    if (xe[CW_X-1]) begin
      if (!ye[CW_X-1]) begin
        xp = ye;
        yp = -xe;
        zp = ANG_HALF_PI;
      end else begin
        xp = -ye;
        yp = xe;
        zp = -ANG_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= xp <<< SH;
      y_r[0]    <= yp <<< SH;
      z_r[0]    <= zp;
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][CW_X-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_lut(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_lut(5'(i));
        end
      end
    end
  end

  // Round Q.29 to Q3.13
  assign zrnd = {z_r[CORDIC_STAGES][ANG_W-1], z_r[CORDIC_STAGES]}
              + {ANG_ROUND[ANG_W-1], ANG_ROUND};

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zero_r[CORDIC_STAGES] ? '0 : zrnd[ANG_W:16];
    end
  end

  assign ang = ang_r;

endmodule

`default_nettype wire

// ----- tb/rotation_matrix_to_euler_tb.sv -----
// Self-checking testbench for the rotation matrix to Z-Y-X Euler angle pipeline.
`timescale 1ns / 1ps

module rotation_matrix_to_euler_tb;
  import rme_pkg::*;

  localparam int DW = 16;
  localparam int LATENCY = 38;
  localparam int RAND_ITEMS = 1800;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [DW-1:0] r00, r10, r11, r12, r20, r21, r22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic singular;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DW-1:0] in_r00 = '0, in_r10 = '0, in_r11 = '0, in_r12 = '0;
  logic signed [DW-1:0] in_r20 = '0, in_r21 = '0, in_r22 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_roll;
  logic signed [14:0] out_pitch;
  logic signed [15:0] out_yaw;
  logic out_singular;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #2 clk = ~clk;

  rotation_matrix_to_euler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_r00(in_r00), .in_r10(in_r10), .in_r11(in_r11), .in_r12(in_r12),
    .in_r20(in_r20), .in_r21(in_r21), .in_r22(in_r22),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll(out_roll), .out_pitch(out_pitch), .out_yaw(out_yaw),
    .out_singular(out_singular),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state and scoreboard
  logic [14:0] threshold_q = 15'd1;
  euler_t angles_pending[$];
  int mismatch_count = 0;
  int angles_checked = 0;
  int singular_seen = 0;
  int idle_cycles = 0;
  bit long_stall = 1'b0;
  bit stall_done = 1'b0;

  // atan(2^-i) in Q.29
  function automatic longint atan_step(int i);
    longint tab[16] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                        16771758, 8387925, 4194219, 2097141, 1048575, 524288,
                        262144, 131072, 65536, 32768, 16384};
    return tab[i];
  endfunction

  // floor division by 2^s
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC arctangent, result in Q3.13
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 843314857;
      end else begin
        t = x; x = -y; y = t; z = -843314857;
      end
    end
    x = x * (longint'(1) << (60 - DW));
    y = y * (longint'(1) << (60 - DW));
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return shr_floor(z + 32768, 16);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic euler_t predict_angles(matrix_t m);
    euler_t e;
    longint sy, a0, a1;
    bit sing;
    a0 = (m.r00 < 0) ? -longint'(m.r00) : longint'(m.r00);
    a1 = (m.r10 < 0) ? -longint'(m.r10) : longint'(m.r10);
    sy = int_sqrt(a0 * a0 + a1 * a1);
    sing = sy < longint'(threshold_q);
    e.pitch = 15'(clip(vector_angle(-longint'(m.r20), sy), 12868));
    if (!sing) begin
      e.roll = 16'(clip(vector_angle(m.r21, m.r22), 25736));
      e.yaw = 16'(clip(vector_angle(m.r10, m.r00), 25736));
    end else begin
      e.roll = 16'(clip(vector_angle(-longint'(m.r12), m.r11), 25736));
      e.yaw = '0;
    end
    e.singular = sing;
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // sender: one matrix transfer, with a random gap before it
  task automatic send_matrix(matrix_t m, bit quick);
    int gap;
    gap = quick ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_r00, in_r10, in_r11, in_r12, in_r20, in_r21, in_r22} <= m;
    angles_pending.push_back(predict_angles(m));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (angles_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(REG_THRESHOLD) << 2;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    threshold_q = value;
    @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_entry();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return DW'($urandom);
    if (k == 1) return DW'($urandom_range(0, 8)) - DW'(4);
    return DW'($urandom_range(0, 32768)) - DW'(16384);
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (long_stall && !stall_done) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin : hold_off
    wait (long_stall);
    repeat (200) @(posedge clk);
    stall_done = 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (angles_pending.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        euler_t want;
        want = angles_pending.pop_front();
        if (out_roll !== want.roll) report_mismatch("roll", out_roll, want.roll);
        if (out_pitch !== want.pitch) report_mismatch("pitch", out_pitch, want.pitch);
        if (out_yaw !== want.yaw) report_mismatch("yaw", out_yaw, want.yaw);
        if (out_singular !== want.singular)
          report_mismatch("singular", out_singular, want.singular);
        if (want.singular) singular_seen++;
        angles_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // directed rows: matrix, expected angles, whether expected is typed in
  typedef struct {
    matrix_t m;
    euler_t e;
    bit typed;
  } directed_row_t;

  localparam logic signed [DW-1:0] ONE = 16'sd16384;
  localparam logic signed [DW-1:0] MONE = -16'sd16384;

  directed_row_t rows[] = '{
    '{'{ONE, 0, ONE, 0, 0, 0, ONE}, '{16'sd0, 15'sd0, 16'sd0, 1'b0}, 1'b1},
    '{'{0, 0, 0, 0, 0, 0, 0}, '{16'sd0, 15'sd0, 16'sd0, 1'b1}, 1'b1},
    '{'{MONE, 0, ONE, 0, 0, 0, MONE}, '{16'sd25736, 15'sd0, 16'sd25736, 1'b0}, 1'b1},
    '{'{0, 0, ONE, 0, MONE, 0, 0}, '{16'sd0, 15'sd12868, 16'sd0, 1'b1}, 1'b1},
    '{'{0, 0, ONE, 0, ONE, 0, 0}, '{16'sd0, -15'sd12868, 16'sd0, 1'b1}, 1'b1},
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{0, 0, 0, 0}, 1'b0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      '{0, 0, 0, 0}, 1'b0},
    '{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
      '{0, 0, 0, 0}, 1'b0},
    '{'{0, ONE, 0, ONE, 0, MONE, 0}, '{0, 0, 0, 0}, 1'b0},
    '{'{0, MONE, 0, MONE, 0, ONE, 0}, '{0, 0, 0, 0}, 1'b0},
    '{'{11585, 11585, 11585, -11585, -8192, 8192, 14189}, '{0, 0, 0, 0}, 1'b0},
    '{'{1, 0, 0, MONE, 0, 0, 0}, '{0, 0, 0, 0}, 1'b0},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, '{0, 0, 0, 0}, 1'b0}
  };

  initial begin : stimulus
    matrix_t m;
    logic [14:0] thresholds[6] = '{15'd0, 15'd16384, 15'd100, 15'd32767, 15'd2000, 15'd1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset threshold
    foreach (rows[i]) begin
      if (rows[i].typed && predict_angles(rows[i].m) !== rows[i].e)
        $display("note: predictor disagrees with typed row %0d", i);
      send_matrix(rows[i].m, 1'b0);
      if (rows[i].typed) angles_pending[$] = rows[i].e;
    end
    drain_results();

    // random phases across thresholds, including both extremes
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thresholds[ph]);
      if (ph == 1) long_stall = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          // near gimbal lock: small r00 and r10
          m = '{rand_entry() >>> $urandom_range(4, 14), rand_entry() >>> $urandom_range(4, 14),
                rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        end else begin
          m = '{rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                rand_entry(), rand_entry(), rand_entry()};
        end
        send_matrix(m, (ph == 1) || ($urandom_range(0, 4) == 0));
      end
      // sender pauses until every result has come
      drain_results();
    end

    $display("covered %0d results, %0d singular, thresholds 0 to 32767 with stalls",
             angles_checked, singular_seen);
    if (mismatch_count == 0 && angles_pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
